// ===== sv/msla_pkg.sv =====
package msla_pkg;

    localparam int MAX_LINE_LENGTH_DEF   = 49;
    localparam int LINE_NUMBER_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TOKEN = 2'd1,
        PH_BODY  = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_OP     = 3'd1;
    localparam logic [2:0] ERR_FORMAT = 3'd2;
    localparam logic [2:0] ERR_REG    = 3'd3;
    localparam logic [2:0] ERR_ADDR   = 3'd4;

    localparam logic [1:0] SH_R = 2'd0;
    localparam logic [1:0] SH_B = 2'd1;
    localparam logic [1:0] SH_M = 2'd2;
    localparam logic [1:0] SH_J = 2'd3;

    localparam logic [2:0] ROLE_RD   = 3'd0;
    localparam logic [2:0] ROLE_RS   = 3'd1;
    localparam logic [2:0] ROLE_RT   = 3'd2;
    localparam logic [2:0] ROLE_IMM  = 3'd3;
    localparam logic [2:0] ROLE_ADDR = 3'd4;

    // template tokens: '#' signed number, 'U' unsigned number, 0 end
    localparam logic [7:0] TC_NUM  = 8'h23;
    localparam logic [7:0] TC_UNUM = 8'h55;
    localparam logic [7:0] TC_END  = 8'h00;

    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [32:0] NUM_SAT = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [2:0]  error_code;
        logic        file_has_error;
    } line_result_t;

    function automatic logic [7:0] shape_char(input logic [1:0] sh, input logic [3:0] pos);
        logic [7:0] c;
        c = TC_END;
        unique case (sh)
            SH_R: unique case (pos)
                4'd0, 4'd4, 4'd8: c = 8'h20;
                4'd1, 4'd5, 4'd9: c = 8'h24;
                4'd2, 4'd6, 4'd10: c = TC_NUM;
                4'd3, 4'd7: c = 8'h2C;
                default: c = TC_END;
            endcase
            SH_B: unique case (pos)
                4'd0, 4'd4, 4'd8: c = 8'h20;
                4'd1, 4'd5: c = 8'h24;
                4'd2, 4'd6, 4'd9: c = TC_NUM;
                4'd3, 4'd7: c = 8'h2C;
                default: c = TC_END;
            endcase
            SH_M: unique case (pos)
                4'd0, 4'd4: c = 8'h20;
                4'd1, 4'd7: c = 8'h24;
                4'd2, 4'd5, 4'd8: c = TC_NUM;
                4'd3: c = 8'h2C;
                4'd6: c = 8'h28;
                4'd9: c = 8'h29;
                default: c = TC_END;
            endcase
            SH_J: unique case (pos)
                4'd0: c = 8'h20;
                4'd1: c = TC_UNUM;
                default: c = TC_END;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [1:0] kind_shape(input logic [3:0] k);
        unique case (k)
            4'd5: return SH_B;
            4'd6, 4'd7: return SH_M;
            4'd8: return SH_J;
            default: return SH_R;
        endcase
    endfunction

    function automatic logic [2:0] kind_role(input logic [3:0] k, input logic [1:0] slot);
        logic [1:0] s;
        s = (slot == 2'd3) ? 2'd2 : slot;
        unique case (k)
            4'd5: unique case (s)
                2'd0: return ROLE_RS;
                2'd1: return ROLE_RT;
                default: return ROLE_IMM;
            endcase
            4'd6, 4'd7: unique case (s)
                2'd0: return ROLE_RT;
                2'd1: return ROLE_IMM;
                default: return ROLE_RS;
            endcase
            4'd8: return ROLE_ADDR;
            default: unique case (s)
                2'd0: return ROLE_RD;
                2'd1: return ROLE_RS;
                default: return ROLE_RT;
            endcase
        endcase
    endfunction

    function automatic logic [5:0] kind_code(input logic [3:0] k);
        unique case (k)
            4'd0: return 6'b100000;
            4'd1: return 6'b100010;
            4'd2: return 6'b100100;
            4'd3: return 6'b100101;
            4'd4: return 6'b101010;
            4'd5: return 6'b000100;
            4'd6: return 6'b100011;
            4'd7: return 6'b101011;
            4'd8: return 6'b000010;
            default: return 6'b100000;
        endcase
    endfunction

    // returns kind in [3:0], bit 4 set when no mnemonic matches
    function automatic logic [4:0] match_kind(input logic [23:0] ch, input logic [2:0] len);
        priority if (len == 3'd3 && ch == 24'h616464) return 5'd0;
        else if (len == 3'd3 && ch == 24'h737562) return 5'd1;
        else if (len == 3'd3 && ch == 24'h616E64) return 5'd2;
        else if (len == 3'd2 && ch == 24'h006F72) return 5'd3;
        else if (len == 3'd3 && ch == 24'h736C74) return 5'd4;
        else if (len == 3'd3 && ch == 24'h626571) return 5'd5;
        else if (len == 3'd2 && ch == 24'h006C77) return 5'd6;
        else if (len == 3'd2 && ch == 24'h007377) return 5'd7;
        else if (len == 3'd1 && ch == 24'h00006A) return 5'd8;
        else return 5'h10;
    endfunction

endpackage

// ===== sv/msla_parser.sv =====
module msla_parser #(
    parameter int MAX_LINE_LENGTH   = msla_pkg::MAX_LINE_LENGTH_DEF,
    parameter int LINE_NUMBER_WIDTH = msla_pkg::LINE_NUMBER_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   text_byte,
    input  logic                         stream_end,
    output logic                         line_done,
    output msla_pkg::line_result_t       result,
    output logic [LINE_NUMBER_WIDTH-1:0] line_num
);

    localparam int LW = $clog2(MAX_LINE_LENGTH + 1);

    msla_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic [23:0] chars_reg, chars_next;
    logic [32:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [4:0]  rd_reg, rd_next, rs_reg, rs_next, rt_reg, rt_next;
    logic [25:0] imm_reg, imm_next;
    logic [2:0]  err_reg, err_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LINE_NUMBER_WIDTH-1:0] cnt_reg, cnt_next;
    logic        seen_reg, seen_next;
    logic [2:0]  tlen_reg, tlen_next;
    logic        lead_reg, lead_next, over_reg, over_next;
    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  nstep_reg, nstep_next, slot_reg, slot_next;

    always_comb
    begin
        logic        is_lf, is_ws, is_eol, digit, fin, uns, body_go, ovf;
        logic [7:0]  tc;
        logic [4:0]  mk;
        logic [2:0]  role;
        logic [32:0] lim, prod;
        logic [3:0]  d;
        logic [15:0] nv;
        logic [31:0] word;

        phase_next = phase_reg; kind_next = kind_reg; chars_next = chars_reg;
        acc_next = acc_reg; neg_next = neg_reg; rd_next = rd_reg; rs_next = rs_reg;
        rt_next = rt_reg; imm_next = imm_reg; err_next = err_reg; len_next = len_reg;
        cnt_next = cnt_reg; seen_next = seen_reg; tlen_next = tlen_reg;
        lead_next = lead_reg; over_next = over_reg; pos_next = pos_reg;
        nstep_next = nstep_reg; slot_next = slot_reg;
        line_done = 1'b0; word = '0; result = '0;
        body_go = 1'b0; tc = '0; mk = '0; role = '0; lim = '0; prod = '0; ovf = 1'b0;
        fin = 1'b0; uns = 1'b0; nv = '0;

        is_lf  = (text_byte == msla_pkg::CH_LF);
        is_eol = is_lf;
        is_ws  = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0B)
              || (text_byte == 8'h0C) || (text_byte == 8'h0D);
        digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        d      = digit ? text_byte[3:0] : 4'd0;

        if (step)
        begin
            if (!is_lf)
            begin
                if (len_reg >= LW'(MAX_LINE_LENGTH)) over_next = 1'b1;
                else len_next = len_reg + LW'(1);
                unique case (phase_reg)
                    msla_pkg::PH_START:
                        if (is_ws) lead_next = 1'b1;
                        else
                        begin
                            phase_next = msla_pkg::PH_TOKEN;
                            chars_next = {chars_reg[15:0], text_byte};
                            if (tlen_reg < 3'd4) tlen_next = tlen_reg + 3'd1;
                        end
                    msla_pkg::PH_TOKEN:
                        if (is_ws) body_go = 1'b1;
                        else
                        begin
                            chars_next = {chars_reg[15:0], text_byte};
                            if (tlen_reg < 3'd4) tlen_next = tlen_reg + 3'd1;
                        end
                    msla_pkg::PH_BODY: body_go = 1'b1;
                    msla_pkg::PH_SKIP: ;
                endcase
            end
            else if (phase_reg == msla_pkg::PH_START) err_next = msla_pkg::ERR_OP;
            else if (phase_reg != msla_pkg::PH_SKIP) body_go = 1'b1;

            // close the mnemonic when the token ends
            if (body_go && phase_reg == msla_pkg::PH_TOKEN)
            begin
                mk = msla_pkg::match_kind(chars_reg, tlen_reg);
                if (mk[4])
                begin
                    err_next = msla_pkg::ERR_OP; phase_next = msla_pkg::PH_SKIP;
                    body_go = 1'b0;
                end
                else
                begin
                    kind_next = mk[3:0];
                    if (lead_reg)
                    begin
                        err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP;
                        body_go = 1'b0;
                    end
                    else
                    begin
                        phase_next = msla_pkg::PH_BODY; pos_next = 4'd0;
                    end
                end
            end

            if (body_go)
            begin
                tc  = msla_pkg::shape_char(msla_pkg::kind_shape(kind_next), pos_next);
                uns = (tc == msla_pkg::TC_UNUM);
                if (tc == msla_pkg::TC_NUM || uns)
                begin
                    unique case (nstep_reg)
                        2'd0:
                            if (text_byte == 8'h2D && !uns && !is_eol)
                            begin neg_next = 1'b1; nstep_next = 2'd1; end
                            else if (text_byte == 8'h30 && !is_eol)
                            begin acc_next = '0; nstep_next = 2'd3; end
                            else if (digit && !is_eol)
                            begin acc_next = 33'(d); nstep_next = 2'd2; end
                            else
                            begin err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP; end
                        2'd1:
                            if (digit && text_byte != 8'h30 && !is_eol)
                            begin acc_next = 33'(d); nstep_next = 2'd2; end
                            else
                            begin err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP; end
                        default:
                            if (nstep_reg == 2'd2 && digit && !is_eol)
                            begin
                                prod = (acc_reg << 3) + (acc_reg << 1) + 33'(d);
                                acc_next = (acc_reg >= 33'd429496730 || prod > 33'hFFFF_FFFF)
                                         ? msla_pkg::NUM_SAT : prod;
                            end
                            else fin = 1'b1;
                    endcase
                end
                else if (tc == msla_pkg::TC_END)
                begin
                    if (!is_eol)
                    begin err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP; end
                end
                else if (!is_eol && text_byte == tc) pos_next = pos_reg + 4'd1;
                else
                begin err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP; end

                if (fin)
                begin
                    lim  = uns ? 33'hFFFF_FFFF : (33'h7FFF_FFFF + 33'(neg_reg));
                    role = msla_pkg::kind_role(kind_reg, slot_reg);
                    ovf  = acc_reg > lim;
                    if (ovf)
                    begin err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP; end
                    else
                    begin
                        unique case (role)
                            msla_pkg::ROLE_IMM:
                            begin
                                nv = neg_reg ? 16'(-acc_reg[15:0]) : acc_reg[15:0];
                                imm_next = 26'(nv);
                            end
                            msla_pkg::ROLE_ADDR:
                            begin
                                if (acc_reg > 33'h3FF_FFFF && err_reg == msla_pkg::ERR_NONE)
                                    err_next = msla_pkg::ERR_ADDR;
                                imm_next = acc_reg[25:0];
                            end
                            default:
                            begin
                                if ((neg_reg || acc_reg > 33'd31) && err_reg == msla_pkg::ERR_NONE)
                                    err_next = msla_pkg::ERR_REG;
                                if (role == msla_pkg::ROLE_RD) rd_next = acc_reg[4:0];
                                else if (role == msla_pkg::ROLE_RS) rs_next = acc_reg[4:0];
                                else rt_next = acc_reg[4:0];
                            end
                        endcase
                        if (slot_reg != 2'd3) slot_next = slot_reg + 2'd1;
                        nstep_next = '0; acc_next = '0; neg_next = 1'b0;
                        // next template char is a literal or the end
                        tc = msla_pkg::shape_char(msla_pkg::kind_shape(kind_reg),
                                                  pos_reg + 4'd1);
                        if (tc == msla_pkg::TC_END)
                        begin
                            if (!is_eol)
                            begin
                                err_next = msla_pkg::ERR_FORMAT;
                                phase_next = msla_pkg::PH_SKIP;
                            end
                            pos_next = pos_reg + 4'd1;
                        end
                        else if (!is_eol && text_byte == tc) pos_next = pos_reg + 4'd2;
                        else
                        begin
                            err_next = msla_pkg::ERR_FORMAT; phase_next = msla_pkg::PH_SKIP;
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                end
            end

            // a stream end on a plain byte closes the line right after that byte
            if (stream_end && !is_lf)
            begin
                unique case (phase_next)
                    msla_pkg::PH_START: err_next = msla_pkg::ERR_OP;
                    msla_pkg::PH_TOKEN:
                    begin
                        mk = msla_pkg::match_kind(chars_next, tlen_next);
                        err_next = mk[4] ? msla_pkg::ERR_OP : msla_pkg::ERR_FORMAT;
                        phase_next = msla_pkg::PH_SKIP;
                    end
                    msla_pkg::PH_BODY:
                    begin
                        tc  = msla_pkg::shape_char(msla_pkg::kind_shape(kind_next), pos_next);
                        uns = (tc == msla_pkg::TC_UNUM);
                        if (tc == msla_pkg::TC_NUM || uns)
                        begin
                            lim  = uns ? 33'hFFFF_FFFF : (33'h7FFF_FFFF + 33'(neg_next));
                            role = msla_pkg::kind_role(kind_next, slot_next);
                            if (nstep_next < 2'd2 || acc_next > lim)
                                err_next = msla_pkg::ERR_FORMAT;
                            else
                            begin
                                unique case (role)
                                    msla_pkg::ROLE_IMM:
                                    begin
                                        nv = neg_next ? 16'(-acc_next[15:0]) : acc_next[15:0];
                                        imm_next = 26'(nv);
                                    end
                                    msla_pkg::ROLE_ADDR:
                                    begin
                                        if (acc_next > 33'h3FF_FFFF
                                            && err_next == msla_pkg::ERR_NONE)
                                            err_next = msla_pkg::ERR_ADDR;
                                        imm_next = acc_next[25:0];
                                    end
                                    default:
                                    begin
                                        if ((neg_next || acc_next > 33'd31)
                                            && err_next == msla_pkg::ERR_NONE)
                                            err_next = msla_pkg::ERR_REG;
                                        if (role == msla_pkg::ROLE_RD) rd_next = acc_next[4:0];
                                        else if (role == msla_pkg::ROLE_RS)
                                            rs_next = acc_next[4:0];
                                        else rt_next = acc_next[4:0];
                                    end
                                endcase
                                tc = msla_pkg::shape_char(msla_pkg::kind_shape(kind_next),
                                                          pos_next + 4'd1);
                                if (tc != msla_pkg::TC_END) err_next = msla_pkg::ERR_FORMAT;
                            end
                        end
                        else if (tc != msla_pkg::TC_END) err_next = msla_pkg::ERR_FORMAT;
                    end
                    msla_pkg::PH_SKIP: ;
                endcase
            end

            if (is_lf || stream_end)
            begin
                line_done = 1'b1;
                if (over_next && err_next != msla_pkg::ERR_OP) err_next = msla_pkg::ERR_FORMAT;
                if (err_next == msla_pkg::ERR_NONE)
                begin
                    if (kind_next < 4'd5)
                        word = {6'd0, rs_next, rt_next, rd_next, 5'd0,
                                msla_pkg::kind_code(kind_next)};
                    else if (kind_next < 4'd8)
                        word = {msla_pkg::kind_code(kind_next), rs_next, rt_next,
                                imm_next[15:0]};
                    else
                        word = {msla_pkg::kind_code(kind_next), imm_next};
                end
                result.instr_word     = word;
                result.error_code     = err_next;
                result.file_has_error = seen_reg || (err_next != msla_pkg::ERR_NONE);
                seen_next = stream_end ? 1'b0 : result.file_has_error;
                cnt_next  = stream_end ? LINE_NUMBER_WIDTH'(1) : cnt_reg + LINE_NUMBER_WIDTH'(1);
                phase_next = msla_pkg::PH_START; kind_next = '0; chars_next = '0;
                acc_next = '0; neg_next = 1'b0; rd_next = '0; rs_next = '0; rt_next = '0;
                imm_next = '0; err_next = msla_pkg::ERR_NONE; len_next = '0; tlen_next = '0;
                lead_next = 1'b0; over_next = 1'b0; pos_next = '0; nstep_next = '0;
                slot_next = '0;
            end
        end
    end

    assign line_num = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= msla_pkg::PH_START; kind_reg <= '0; chars_reg <= '0; acc_reg <= '0;
            neg_reg <= 1'b0; rd_reg <= '0; rs_reg <= '0; rt_reg <= '0; imm_reg <= '0;
            err_reg <= msla_pkg::ERR_NONE; len_reg <= '0; cnt_reg <= LINE_NUMBER_WIDTH'(1);
            seen_reg <= 1'b0; tlen_reg <= '0; lead_reg <= 1'b0; over_reg <= 1'b0;
            pos_reg <= '0; nstep_reg <= '0; slot_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next; kind_reg <= kind_next; chars_reg <= chars_next;
            acc_reg <= acc_next; neg_reg <= neg_next; rd_reg <= rd_next; rs_reg <= rs_next;
            rt_reg <= rt_next; imm_reg <= imm_next; err_reg <= err_next; len_reg <= len_next;
            cnt_reg <= cnt_next; seen_reg <= seen_next; tlen_reg <= tlen_next;
            lead_reg <= lead_next; over_reg <= over_next; pos_reg <= pos_next;
            nstep_reg <= nstep_next; slot_reg <= slot_next;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_LINE_LENGTH)) else $error("line length past limit");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        line_done |=> phase_reg == msla_pkg::PH_START && err_reg == msla_pkg::ERR_NONE)
        else $error("line state not cleared");
    a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        line_done && result.error_code != msla_pkg::ERR_NONE |-> result.instr_word == '0)
        else $error("word not zero on error");
    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && stream_end |=> cnt_reg == LINE_NUMBER_WIDTH'(1) && !seen_reg)
        else $error("stream end did not restart");

endmodule

// ===== sv/mips_subset_line_assembler.sv =====
// Byte-serial assembler for add, sub, and, or, slt, beq, lw, sw and j.
// Input channel s_axis: one text character a beat, tdata = text_byte,
// tuser = stream_end (closes the line and, after its result, restarts
// line numbering and clears the file error flag). Byte 10 ends a line.
// Output channel m_axis: one beat per line end. tdata holds instr_word,
// error_code, line_number; tuser holds file_has_error.
// Throughput: one byte per cycle while s_axis_tready is high. The parser
// forms a line's result combinationally from the byte that closes it and
// the output buffer registers it; it heads m_axis once older results go.
// A two-entry output skid buffer lets input flow continue while a result
// waits; s_axis_tready drops only when both entries hold results.
// Reset (rst_n low, asynchronous) returns to line 1 with no file error
// and empties the output buffer. A stalled receiver only holds back input
// once the buffer is full; nothing is lost or repeated.
module mips_subset_line_assembler #(
    parameter int MAX_LINE_LENGTH   = msla_pkg::MAX_LINE_LENGTH_DEF,
    parameter int LINE_NUMBER_WIDTH = msla_pkg::LINE_NUMBER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tuser,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // instr_word[31:0], error_code[34:32],
                                        // line_number[50:35], zero fill
    output logic        m_axis_tuser    // file_has_error
);

    localparam int OW = 32 + 3 + 16 + 1;

    logic step, line_done;
    msla_pkg::line_result_t res;
    logic [LINE_NUMBER_WIDTH-1:0] lnum;
    logic [OW-1:0] pack;
    logic [OW-1:0] buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign step = s_axis_tvalid && s_axis_tready;

    msla_parser #(
        .MAX_LINE_LENGTH(MAX_LINE_LENGTH),
        .LINE_NUMBER_WIDTH(LINE_NUMBER_WIDTH)
    ) u_parser (
        .clk(clk), .rst_n(rst_n), .step(step), .text_byte(s_axis_tdata),
        .stream_end(s_axis_tuser), .line_done(line_done), .result(res), .line_num(lnum)
    );

    assign pack = {res.file_has_error, 16'(lnum), res.error_code, res.instr_word};
    assign push = line_done;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= '0;
        else cnt_reg <= cnt_next;
    end

    // entry 0 is the head; shift on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf_reg[0] <= (cnt_reg == 2'd2) ? buf_reg[1] : pack;
            if (push && cnt_reg == 2'd2) buf_reg[1] <= pack;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0) buf_reg[0] <= pack;
            else buf_reg[1] <= pack;
        end
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {5'd0, buf_reg[0][OW-2:0]};
    assign m_axis_tuser  = buf_reg[0][OW-1];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("buffer count invalid");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !step) else $error("accepted while full");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

endmodule
